@@ rtl/core/ldpm_pkg.sv @@
// Shared types, constants and helper functions for the lens distortion point mapper.
// No dependencies; all modules but ldpm_checker refer to this package by scoped name.
package ldpm_pkg;

    localparam int FOCAL_WIDTH     = 24;
    localparam int COEF_WIDTH      = 32;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic signed [COEF_WIDTH-1:0] t_coef;
    typedef logic        [FOCAL_WIDTH-1:0] t_focal;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FOCAL_X     = 3'd0,
        CFG_FOCAL_Y     = 3'd1,
        CFG_CENTER_X    = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_RADIAL_K1   = 3'd4,
        CFG_RADIAL_K2   = 3'd5,
        CFG_RADIAL_K3   = 3'd6,
        CFG_TANGENTIAL  = 3'd7
    } t_cfg_index;

    typedef struct packed {
        t_coef k1;
        t_coef k2;
        t_coef k3;
        t_coef p1;
        t_coef p2;
    } t_lens_coef;

    localparam t_coef COEF_MAX = 32'sh7FFF_FFFF;
    localparam t_coef COEF_MIN = 32'sh8000_0000;

    // Clamp a wide signed value to the normalized 32-bit range.
    function automatic t_coef sat_coef(input logic signed [63:0] v);
        t_coef r;
        if (v > 64'(COEF_MAX)) begin
            r = COEF_MAX;
        end else if (v < 64'(COEF_MIN)) begin
            r = COEF_MIN;
        end else begin
            r = v[COEF_WIDTH-1:0];
        end
        return r;
    endfunction

    // Drop frac fraction bits, rounding to nearest with ties away from zero.
    function automatic logic signed [63:0] round_frac(input logic signed [63:0] p,
                                                      input int frac);
        logic signed [63:0] half;
        logic signed [63:0] bias;
        half = 64'sd1 <<< (frac - 1);
        bias = $signed(64'(p[63]));
        return (p + half - bias) >>> frac;
    endfunction

endpackage

@@ rtl/core/ldpm_point_if.sv @@
// Input channel of the lens distortion point mapper: one ideal pixel position per item.
// Standalone; width follows the COORD_WIDTH parameter.
interface ldpm_point_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

@@ rtl/core/ldpm_result_if.sv @@
// Output channel of the lens distortion point mapper: one distorted pixel position per item.
// Standalone; width follows the COORD_WIDTH parameter.
interface ldpm_result_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] distorted_x;
    logic signed [COORD_WIDTH-1:0] distorted_y;
    logic                          clipped;

    modport source (output valid, output distorted_x, output distorted_y, output clipped,
                    input ready);
    modport sink   (input valid, input distorted_x, input distorted_y, input clipped,
                    output ready);
endinterface

@@ rtl/core/ldpm_qmul.sv @@
// Two-stage fixed-point multiplier: registered 32x32 product, then rounding and clamping.
// Depends on ldpm_pkg.
module ldpm_qmul #(
    parameter int FRAC = 24
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  ldpm_pkg::t_coef i_a,
    input  ldpm_pkg::t_coef i_b,
    output ldpm_pkg::t_coef o_q
);
    logic signed [63:0] r_prod;
    ldpm_pkg::t_coef    r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 64'(i_a) * 64'(i_b);
            r_q    <= ldpm_pkg::sat_coef(ldpm_pkg::round_frac(r_prod, FRAC));
        end
    end

    assign o_q = r_q;
endmodule

@@ rtl/core/ldpm_norm_div.sv @@
// Pipelined normalizer: (point - center) / focal in Q.FRAC, one quotient bit per stage.
// Depends on ldpm_pkg.
module ldpm_norm_div #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC        = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_point,
    input  logic signed [COORD_WIDTH-1:0] i_center,
    input  ldpm_pkg::t_focal              i_focal,
    output logic                          o_valid,
    output ldpm_pkg::t_coef               o_norm
);
    localparam int FW     = ldpm_pkg::FOCAL_WIDTH;
    localparam int QW     = ldpm_pkg::COEF_WIDTH;
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int NUM_W  = COORD_WIDTH + FRAC + 2;
    localparam int CMP_W  = (NUM_W > FW + QW) ? NUM_W : FW + QW;
    localparam int LAT    = QW + 3;
    localparam logic [QW-1:0] MAG_MIN = QW'(1) << (QW - 1);

    logic [LAT-1:0] r_vld;

    // Magnitude and sign of the offset from the principal point
    logic signed [DIFF_W-1:0] n_diff;
    logic        [DIFF_W-1:0] n_mag;
    logic        [DIFF_W-1:0] r_a_mag;
    logic                     r_a_neg;

    assign n_diff = DIFF_W'(i_point) - DIFF_W'(i_center);
    assign n_mag  = n_diff[DIFF_W-1] ? DIFF_W'(-n_diff) : n_diff;

    // Rounded dividend, overflow check and initial partial remainder
    logic [NUM_W-1:0] n_num;
    logic             n_ovf;
    logic [FW-1:0]    r_rem [QW+1];
    logic [QW-1:0]    r_lo  [QW+1];
    logic             r_neg [QW+1];
    logic             r_ovf [QW+1];

    assign n_num = (NUM_W'(r_a_mag) << FRAC) + NUM_W'(i_focal >> 1);
    assign n_ovf = CMP_W'(n_num) >= (CMP_W'(i_focal) << QW);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag  <= n_mag;
            r_a_neg  <= n_diff[DIFF_W-1];
            r_rem[0] <= FW'(CMP_W'(n_num) >> QW);
            r_lo[0]  <= n_num[QW-1:0];
            r_neg[0] <= r_a_neg;
            r_ovf[0] <= n_ovf;
        end
    end

    // Restoring division: the low word shifts dividend bits out and quotient bits in
    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [FW:0] w_trial;
        logic        w_ge;

        assign w_trial = {r_rem[s], r_lo[s][QW-1]};
        assign w_ge    = w_trial >= {1'b0, i_focal};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? FW'(w_trial - {1'b0, i_focal}) : w_trial[FW-1:0];
                r_lo[s+1]  <= {r_lo[s][QW-2:0], w_ge};
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    // Apply sign and clamp to the normalized range
    logic [QW-1:0]   n_q;
    ldpm_pkg::t_coef n_norm;
    ldpm_pkg::t_coef r_norm;

    always_comb begin
        n_q = r_lo[QW];
        if (!r_neg[QW]) begin
            n_norm = (r_ovf[QW] || n_q[QW-1]) ? ldpm_pkg::COEF_MAX : $signed(n_q);
        end else begin
            n_norm = (r_ovf[QW] || n_q > MAG_MIN) ? ldpm_pkg::COEF_MIN : $signed(-n_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm <= n_norm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_norm  = r_norm;
endmodule

@@ rtl/core/ldpm_poly.sv @@
// Brown-Conrady polynomial in normalized coordinates, built from pipelined ldpm_qmul multipliers.
// Depends on ldpm_pkg and ldpm_qmul.
module ldpm_poly #(
    parameter int FRAC = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ldpm_pkg::t_coef      i_xn,
    input  ldpm_pkg::t_coef      i_yn,
    input  ldpm_pkg::t_lens_coef i_coef,
    output logic                 o_valid,
    output ldpm_pkg::t_coef      o_xd,
    output ldpm_pkg::t_coef      o_yd
);
    localparam int LAT = 13;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC;

    logic [LAT-1:0] r_vld;

    // Squares and cross term
    ldpm_pkg::t_coef w_x2, w_y2, w_xy;

    ldpm_qmul #(.FRAC(FRAC)) u_x2 (.i_clk, .i_en, .i_a(i_xn), .i_b(i_xn), .o_q(w_x2));
    ldpm_qmul #(.FRAC(FRAC)) u_y2 (.i_clk, .i_en, .i_a(i_yn), .i_b(i_yn), .o_q(w_y2));
    ldpm_qmul #(.FRAC(FRAC)) u_xy (.i_clk, .i_en, .i_a(i_xn), .i_b(i_yn), .o_q(w_xy));

    // r2 and the tangential sums r2 + 2x2, r2 + 2y2; squares are never negative
    logic signed [63:0] n_r2_sum;
    ldpm_pkg::t_coef    r_r2, r_tx, r_ty, r_xy;

    assign n_r2_sum = 64'(w_x2) + 64'(w_y2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r2 <= ldpm_pkg::sat_coef(n_r2_sum);
            r_tx <= ldpm_pkg::sat_coef(n_r2_sum + (64'(w_x2) <<< 1));
            r_ty <= ldpm_pkg::sat_coef(n_r2_sum + (64'(w_y2) <<< 1));
            r_xy <= w_xy;
        end
    end

    ldpm_pkg::t_coef w_r4, w_k1r2, w_p2tx, w_p1ty, w_p1xy, w_p2xy;

    ldpm_qmul #(.FRAC(FRAC)) u_r4   (.i_clk, .i_en, .i_a(r_r2), .i_b(r_r2), .o_q(w_r4));
    ldpm_qmul #(.FRAC(FRAC)) u_k1r2 (.i_clk, .i_en, .i_a(i_coef.k1), .i_b(r_r2),
                                     .o_q(w_k1r2));
    ldpm_qmul #(.FRAC(FRAC)) u_p2tx (.i_clk, .i_en, .i_a(i_coef.p2), .i_b(r_tx),
                                     .o_q(w_p2tx));
    ldpm_qmul #(.FRAC(FRAC)) u_p1ty (.i_clk, .i_en, .i_a(i_coef.p1), .i_b(r_ty),
                                     .o_q(w_p1ty));
    ldpm_qmul #(.FRAC(FRAC)) u_p1xy (.i_clk, .i_en, .i_a(i_coef.p1), .i_b(r_xy),
                                     .o_q(w_p1xy));
    ldpm_qmul #(.FRAC(FRAC)) u_p2xy (.i_clk, .i_en, .i_a(i_coef.p2), .i_b(r_xy),
                                     .o_q(w_p2xy));

    // Higher powers of r2
    ldpm_pkg::t_coef r_r2_dly [2];
    ldpm_pkg::t_coef w_r6, w_k2r4, w_k3r6;

    ldpm_qmul #(.FRAC(FRAC)) u_r6   (.i_clk, .i_en, .i_a(w_r4), .i_b(r_r2_dly[1]),
                                     .o_q(w_r6));
    ldpm_qmul #(.FRAC(FRAC)) u_k2r4 (.i_clk, .i_en, .i_a(i_coef.k2), .i_b(w_r4),
                                     .o_q(w_k2r4));
    ldpm_qmul #(.FRAC(FRAC)) u_k3r6 (.i_clk, .i_en, .i_a(i_coef.k3), .i_b(w_r6),
                                     .o_q(w_k3r6));

    // Align terms with their consumers
    ldpm_pkg::t_coef r_k1r2_dly [4];
    ldpm_pkg::t_coef r_k2r4_dly [2];
    ldpm_pkg::t_coef r_xn_dly   [10];
    ldpm_pkg::t_coef r_yn_dly   [10];
    ldpm_pkg::t_coef r_p1xy_dly [7];
    ldpm_pkg::t_coef r_p2xy_dly [7];
    ldpm_pkg::t_coef r_p2tx_dly [7];
    ldpm_pkg::t_coef r_p1ty_dly [7];
    ldpm_pkg::t_coef r_rad;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r2_dly[0]   <= r_r2;
            r_r2_dly[1]   <= r_r2_dly[0];
            r_k1r2_dly[0] <= w_k1r2;
            for (int i = 1; i < 4; i++) begin
                r_k1r2_dly[i] <= r_k1r2_dly[i-1];
            end
            r_k2r4_dly[0] <= w_k2r4;
            r_k2r4_dly[1] <= r_k2r4_dly[0];
            r_xn_dly[0]   <= i_xn;
            r_yn_dly[0]   <= i_yn;
            for (int i = 1; i < 10; i++) begin
                r_xn_dly[i] <= r_xn_dly[i-1];
                r_yn_dly[i] <= r_yn_dly[i-1];
            end
            r_p1xy_dly[0] <= w_p1xy;
            r_p2xy_dly[0] <= w_p2xy;
            r_p2tx_dly[0] <= w_p2tx;
            r_p1ty_dly[0] <= w_p1ty;
            for (int i = 1; i < 7; i++) begin
                r_p1xy_dly[i] <= r_p1xy_dly[i-1];
                r_p2xy_dly[i] <= r_p2xy_dly[i-1];
                r_p2tx_dly[i] <= r_p2tx_dly[i-1];
                r_p1ty_dly[i] <= r_p1ty_dly[i-1];
            end
            r_rad <= ldpm_pkg::sat_coef(ONE + 64'(r_k1r2_dly[3]) + 64'(r_k2r4_dly[1])
                                        + 64'(w_k3r6));
        end
    end

    // Radial scaling and final sums
    ldpm_pkg::t_coef w_xr, w_yr;
    ldpm_pkg::t_coef r_xd, r_yd;

    ldpm_qmul #(.FRAC(FRAC)) u_xr (.i_clk, .i_en, .i_a(r_xn_dly[9]), .i_b(r_rad), .o_q(w_xr));
    ldpm_qmul #(.FRAC(FRAC)) u_yr (.i_clk, .i_en, .i_a(r_yn_dly[9]), .i_b(r_rad), .o_q(w_yr));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xd <= ldpm_pkg::sat_coef(64'(w_xr) + (64'(r_p1xy_dly[6]) <<< 1)
                                       + 64'(r_p2tx_dly[6]));
            r_yd <= ldpm_pkg::sat_coef(64'(w_yr) + 64'(r_p1ty_dly[6])
                                       + (64'(r_p2xy_dly[6]) <<< 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_xd    = r_xd;
    assign o_yd    = r_yd;
endmodule

@@ rtl/core/ldpm_pixel.sv @@
// Maps a normalized coordinate back to pixels: scale by focal, round, add center, clamp.
// Depends on ldpm_pkg.
module ldpm_pixel #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC        = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ldpm_pkg::t_coef               i_norm,
    input  ldpm_pkg::t_focal              i_focal,
    input  logic signed [COORD_WIDTH-1:0] i_center,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_coord,
    output logic                          o_clip
);
    localparam int LAT = 3;
    localparam logic signed [63:0] PIX_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] PIX_MIN = -(64'sd1 <<< (COORD_WIDTH - 1));

    logic [LAT-1:0]                r_vld;
    logic signed [63:0]            r_prod;
    logic signed [63:0]            r_rnd;
    logic signed [63:0]            n_sum;
    logic signed [COORD_WIDTH-1:0] n_coord;
    logic                          n_clip;
    logic signed [COORD_WIDTH-1:0] r_coord;
    logic                          r_clip;

    always_comb begin
        n_sum   = r_rnd + 64'(i_center);
        n_clip  = 1'b0;
        n_coord = n_sum[COORD_WIDTH-1:0];
        if (n_sum > PIX_MAX) begin
            n_coord = PIX_MAX[COORD_WIDTH-1:0];
            n_clip  = 1'b1;
        end else if (n_sum < PIX_MIN) begin
            n_coord = PIX_MIN[COORD_WIDTH-1:0];
            n_clip  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= 64'(i_norm) * 64'($signed({1'b0, i_focal}));
            r_rnd   <= ldpm_pkg::round_frac(r_prod, FRAC);
            r_coord <= n_coord;
            r_clip  <= n_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_coord = r_coord;
    assign o_clip  = r_clip;
endmodule

@@ rtl/core/lens_distortion_point_mapper_top.sv @@
// Top level of the lens distortion point mapper (Brown-Conrady, k1 k2 k3 p1 p2).
// Depends on ldpm_pkg, ldpm_point_if, ldpm_result_if, ldpm_norm_div, ldpm_poly, ldpm_pixel.
//
//  Port       | Dir | Handshake     | Item contents
//  -----------+-----+---------------+-------------------------------------------------
//  i_point    | in  | valid / ready | point_x, point_y (signed Q.8)
//  o_result   | out | valid / ready | distorted_x, distorted_y (signed Q.8), clipped
//  i_cfg_*    | in  | write enable  | i_cfg_index selects register, i_cfg_data value
//
//  One item per clock sustained while the spare output entry is empty.
//  The normalizing divider has 32 one-bit quotient stages per axis.
//  Reset (synchronous, active low) zeroes valid bits, centers, coefficients; focal = 256.
//  All stages advance together while the two-entry output buffer has room, so a
//  result waiting at o_result does not block i_point until the spare entry fills.
module lens_distortion_point_mapper_top #(
    parameter int COORD_WIDTH    = 24,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [ldpm_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [ldpm_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    ldpm_point_if.sink                            i_point,
    ldpm_result_if.source                         o_result
);
    localparam int CW = ldpm_pkg::COEF_WIDTH;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          clip;
    } t_result;

    // Config registers; the user writes them only while no item is in flight (unenforced)
    ldpm_pkg::t_focal              r_focal_x, r_focal_y;
    logic signed [COORD_WIDTH-1:0] r_center_x, r_center_y;
    ldpm_pkg::t_lens_coef          r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= ldpm_pkg::FOCAL_WIDTH'(256);
            r_focal_y  <= ldpm_pkg::FOCAL_WIDTH'(256);
            r_center_x <= '0;
            r_center_y <= '0;
            r_coef     <= '0;
        end else if (i_cfg_wr_en) begin
            case (ldpm_pkg::t_cfg_index'(i_cfg_index))
                ldpm_pkg::CFG_FOCAL_X:    r_focal_x  <= i_cfg_data[ldpm_pkg::FOCAL_WIDTH-1:0];
                ldpm_pkg::CFG_FOCAL_Y:    r_focal_y  <= i_cfg_data[ldpm_pkg::FOCAL_WIDTH-1:0];
                ldpm_pkg::CFG_CENTER_X:   r_center_x <= i_cfg_data[COORD_WIDTH-1:0];
                ldpm_pkg::CFG_CENTER_Y:   r_center_y <= i_cfg_data[COORD_WIDTH-1:0];
                ldpm_pkg::CFG_RADIAL_K1:  r_coef.k1  <= i_cfg_data[CW-1:0];
                ldpm_pkg::CFG_RADIAL_K2:  r_coef.k2  <= i_cfg_data[CW-1:0];
                ldpm_pkg::CFG_RADIAL_K3:  r_coef.k3  <= i_cfg_data[CW-1:0];
                ldpm_pkg::CFG_TANGENTIAL: begin
                    r_coef.p1 <= i_cfg_data[CW-1:0];
                    r_coef.p2 <= i_cfg_data[2*CW-1:CW];
                end
                default: ;
            endcase
        end
    end

    // A zero focal length acts as the smallest step, 1/256 pixel
    ldpm_pkg::t_focal w_fx, w_fy;

    assign w_fx = (r_focal_x == '0) ? ldpm_pkg::FOCAL_WIDTH'(1) : r_focal_x;
    assign w_fy = (r_focal_y == '0) ? ldpm_pkg::FOCAL_WIDTH'(1) : r_focal_y;

    // Pipeline advance: hold every stage once the spare output entry is taken
    logic r_out_valid, r_skid_valid;
    logic w_en;

    assign w_en          = !r_skid_valid;
    assign i_point.ready = w_en;

    // Normalize both axes
    logic            w_nx_valid, w_ny_valid;
    ldpm_pkg::t_coef w_xn, w_yn;

    ldpm_norm_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC(COEF_FRAC_BITS)) u_div_x (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_point.valid),
        .i_point(i_point.point_x), .i_center(r_center_x), .i_focal(w_fx),
        .o_valid(w_nx_valid), .o_norm(w_xn)
    );

    ldpm_norm_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC(COEF_FRAC_BITS)) u_div_y (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_point.valid),
        .i_point(i_point.point_y), .i_center(r_center_y), .i_focal(w_fy),
        .o_valid(w_ny_valid), .o_norm(w_yn)
    );

    // Lens model
    logic            w_poly_valid;
    ldpm_pkg::t_coef w_xd, w_yd;

    ldpm_poly #(.FRAC(COEF_FRAC_BITS)) u_poly (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_nx_valid && w_ny_valid),
        .i_xn(w_xn), .i_yn(w_yn), .i_coef(r_coef),
        .o_valid(w_poly_valid), .o_xd(w_xd), .o_yd(w_yd)
    );

    // Back to pixels
    logic                          w_px_valid, w_py_valid;
    logic signed [COORD_WIDTH-1:0] w_px, w_py;
    logic                          w_clip_x, w_clip_y;

    ldpm_pixel #(.COORD_WIDTH(COORD_WIDTH), .FRAC(COEF_FRAC_BITS)) u_pix_x (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_poly_valid),
        .i_norm(w_xd), .i_focal(w_fx), .i_center(r_center_x),
        .o_valid(w_px_valid), .o_coord(w_px), .o_clip(w_clip_x)
    );

    ldpm_pixel #(.COORD_WIDTH(COORD_WIDTH), .FRAC(COEF_FRAC_BITS)) u_pix_y (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_poly_valid),
        .i_norm(w_yd), .i_focal(w_fy), .i_center(r_center_y),
        .o_valid(w_py_valid), .o_coord(w_py), .o_clip(w_clip_y)
    );

    // Two-entry output buffer: output register plus one spare entry
    t_result r_out, r_skid, w_new;
    logic    w_push, w_pop;

    assign w_new  = '{x: w_px, y: w_py, clip: w_clip_x || w_clip_y};
    assign w_push = w_px_valid && w_py_valid && w_en;
    assign w_pop  = r_out_valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // Pipeline is held; drain the spare entry into the output register
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= w_new;
            end else begin
                r_skid <= w_new;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.distorted_x = r_out.x;
    assign o_result.distorted_y = r_out.y;
    assign o_result.clipped     = r_out.clip;
endmodule

@@ rtl/core/ldpm_checker.sv @@
// Port-level checks for the lens distortion point mapper, attached by bind.
// Depends on lens_distortion_point_mapper_top.
module ldpm_checker #(
    parameter int COORD_WIDTH = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [COORD_WIDTH-1:0] i_out_x,
    input logic signed [COORD_WIDTH-1:0] i_out_y,
    input logic                          i_out_clipped
);
    localparam logic signed [COORD_WIDTH-1:0] PIX_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] PIX_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Items taken but not yet delivered
    logic [7:0] r_inflight;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_inflight <= r_inflight + 8'd1;
        end else if (w_out_acc && !w_in_acc) begin
            r_inflight <= r_inflight - 8'd1;
        end
    end

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != 8'd0)
        else $error("result shown with no item in flight");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output is empty");

    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_clipped) |->
            (i_out_x == PIX_MAX || i_out_x == PIX_MIN ||
             i_out_y == PIX_MAX || i_out_y == PIX_MIN))
        else $error("clipped set but no coordinate at a range limit");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_clipped)))
        else $error("stalled result changed or dropped");
endmodule

bind lens_distortion_point_mapper_top ldpm_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ldpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_point.valid),
    .i_in_ready    (i_point.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_x       (o_result.distorted_x),
    .i_out_y       (o_result.distorted_y),
    .i_out_clipped (o_result.clipped)
);
